/* src/cbfir_pkg.sv */
// cbfir_pkg: shared types and constants of the circular buffer fir filter
// request and response payload structs, request codes, field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbfir_pkg;

   localparam int CFG_W        = 7;
   localparam int SAMPLE_BITS  = 16;
   localparam int TAP_BITS     = 16;
   localparam int TAP_IDX_W    = 6;
   localparam int OUT_W        = 40;
   localparam int POS_W        = 6;
   localparam int CSR_IDX_W    = 1;
   localparam int DEPTH_DEF    = 64;
   localparam int MIN_LEN      = 2;

   localparam logic [CFG_W-1:0] USED_LEN_RST = CFG_W'(64);
   localparam logic [CFG_W-1:0] NUM_TAPS_RST = CFG_W'(1);

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_BLOCK = 2'd1,
      REQ_TAP   = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

   typedef struct packed {
      req_code_type                  req_type;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [TAP_IDX_W-1:0]          tap_index;
      logic signed [TAP_BITS-1:0]    tap_value;
   } cbfir_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] fir_out;
      logic [POS_W-1:0]        out_position;
      logic                    last_of_run;
   } cbfir_rsp_type;

endpackage

`default_nettype wire

/* src/cbfir_ram.sv */
// cbfir_ram: single write port, single read port synchronous store
// per-entry valid bits make unwritten or cleared entries read as zero
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module cbfir_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rdata_ff;
   logic             rvld_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
      if (reset) begin
         rvld_ff <= 1'b0;
      end else begin
         rvld_ff <= valid_ff[raddr];
      end
   end

   assign rdata = rvld_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

/* src/cbfir_mac.sv */
// cbfir_mac: registered multiplier followed by a 40-bit accumulator
// depends on cbfir_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbfir_mac
   import cbfir_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       clear,
   input  wire logic                       term_valid,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire logic signed [TAP_BITS-1:0]    tap,
   output logic signed [OUT_W-1:0]         acc,
   output logic                            prod_pending
);

   localparam int PROD_W = SAMPLE_BITS + TAP_BITS;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic signed [OUT_W-1:0]  acc_ff;

   always_ff @(posedge clock) begin
      prod_ff <= sample * tap;
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= term_valid;
         if (clear) begin
            acc_ff <= '0;
         end else if (prod_vld_ff) begin
            acc_ff <= acc_ff + OUT_W'(prod_ff);
         end
      end
   end

   assign acc          = acc_ff;
   assign prod_pending = prod_vld_ff;

endmodule

`default_nettype wire

/* src/circular_buffer_fir_filter.sv */
// circular_buffer_fir_filter: top level, request sequencer and config registers
// depends on cbfir_pkg, cbfir_ram, cbfir_mac
//
//   port group   direction   payload          handshake
//   req_*        in          cbfir_req_type   req_valid / req_ready
//   rsp_*        out         cbfir_rsp_type   rsp_valid / rsp_ready
//   csr_*        in          index, 7b data   csr_valid / csr_ready (always ready)
//
// one request at a time; a push issues T terms, none if T is 0
// a block request issues min(T, f + 1) terms for each position f, none if T is 0
// through the single multiply-accumulate unit and one read port per store, one term a cycle,
// each term passing the read, multiply and accumulate registers before the response register
// reset clears sample and tap stores at once through their valid bits, no sweep
// a stalled response holds the sequencer in its drain state until taken

`timescale 1ns / 1ps
`default_nettype none

module circular_buffer_fir_filter
   import cbfir_pkg::*;
#(
   parameter int BUF_DEPTH = DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire cbfir_req_type        req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output cbfir_rsp_type             rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CW = $clog2(BUF_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_USED_LEN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_TAPS = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type     state_ff, state_in;
   logic [CFG_W-1:0] used_len_ff, num_taps_ff;
   logic [AW-1:0] wp_ff, wp_in;
   logic          mode_blk_ff, mode_blk_in;
   logic [AW-1:0] f_ff, f_in;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] term_ff, term_in;
   logic [CW-1:0] nterm_ff, nterm_in;
   logic          issue_vld_ff, issue_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   cbfir_rsp_type rsp_data_ff, rsp_data_in;

   logic [CFG_W-1:0] len_wide, taps_wide;
   logic [CW-1:0]    len_eff, taps_eff;
   logic [AW-1:0]    head_eff, len_last, base_nx;
   logic [CW-1:0]    f_plus2, nterm_nx;
   logic             req_fire, pipe_busy, slot_free, emit, run_last;

   logic                    smp_we, smp_clr, tap_we;
   logic [AW-1:0]           smp_waddr;
   logic [SAMPLE_BITS-1:0]  smp_rdata;
   logic [TAP_BITS-1:0]     tap_rdata;
   logic signed [OUT_W-1:0] acc;
   logic                    prod_pending;
   logic                    acc_clr;

   // effective length, tap count and head from the config registers
   always_comb begin
      if (used_len_ff < CFG_W'(MIN_LEN)) begin
         len_wide = CFG_W'(MIN_LEN);
      end else if (used_len_ff > CFG_W'(BUF_DEPTH)) begin
         len_wide = CFG_W'(BUF_DEPTH);
      end else begin
         len_wide = used_len_ff;
      end
      taps_wide = (num_taps_ff < len_wide) ? num_taps_ff : len_wide;
   end

   assign len_eff  = CW'(len_wide);
   assign taps_eff = CW'(taps_wide);
   assign head_eff = (CFG_W'(wp_ff) < len_wide) ? wp_ff : '0;
   assign len_last = AW'(len_eff - CW'(1));

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign pipe_busy = issue_vld_ff || prod_pending;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = (state_ff == ST_DRAIN) && !pipe_busy && slot_free;
   assign run_last  = !mode_blk_ff || (CW'(f_ff) + CW'(1) == len_eff);
   assign acc_clr   = req_fire || emit;

   // next block position: base moves forward one, term count grows to the tap count
   assign base_nx  = (CW'(base_ff) + CW'(1) == len_eff) ? '0 : AW'(base_ff + AW'(1));
   assign f_plus2  = CW'(f_ff) + CW'(2);
   assign nterm_nx = (taps_eff < f_plus2) ? taps_eff : f_plus2;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      mode_blk_in  = mode_blk_ff;
      f_in         = f_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      term_in      = term_ff;
      nterm_in     = nterm_ff;
      issue_vld_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      smp_we       = 1'b0;
      smp_clr      = 1'b0;
      smp_waddr    = head_eff;
      tap_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               f_in    = '0;
               base_in = head_eff;
               idx_in  = head_eff;
               term_in = '0;
               unique case (req_data.req_type)
                  REQ_PUSH: begin
                     smp_we      = 1'b1;
                     wp_in       = (CW'(head_eff) + CW'(1) == len_eff) ? '0
                                   : AW'(head_eff + AW'(1));
                     mode_blk_in = 1'b0;
                     nterm_in    = taps_eff;
                     state_in    = (taps_eff == '0) ? ST_DRAIN : ST_ISSUE;
                  end
                  REQ_BLOCK: begin
                     mode_blk_in = 1'b1;
                     nterm_in    = (taps_eff == '0) ? '0 : CW'(1);
                     state_in    = (taps_eff == '0) ? ST_DRAIN : ST_ISSUE;
                  end
                  REQ_TAP: begin
                     tap_we = (CFG_W'(req_data.tap_index) < CFG_W'(BUF_DEPTH));
                  end
                  REQ_CLEAR: begin
                     smp_clr = 1'b1;
                     wp_in   = '0;
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            issue_vld_in = 1'b1;
            if (term_ff + CW'(1) == nterm_ff) begin
               state_in = ST_DRAIN;
            end else begin
               term_in = term_ff + CW'(1);
               idx_in  = (idx_ff == '0) ? len_last : AW'(idx_ff - AW'(1));
            end
         end
         ST_DRAIN: begin
            if (emit) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.fir_out       = acc;
               rsp_data_in.out_position  = POS_W'(f_ff);
               rsp_data_in.last_of_run   = run_last;
               if (run_last) begin
                  state_in = ST_IDLE;
               end else begin
                  f_in     = AW'(f_ff + AW'(1));
                  base_in  = base_nx;
                  idx_in   = base_nx;
                  term_in  = '0;
                  nterm_in = nterm_nx;
                  state_in = (nterm_nx == '0) ? ST_DRAIN : ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      f_ff        <= f_in;
      base_ff     <= base_in;
      idx_ff      <= idx_in;
      term_ff     <= term_in;
      nterm_ff    <= nterm_in;
      mode_blk_ff <= mode_blk_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         issue_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_len_ff  <= USED_LEN_RST;
         num_taps_ff  <= NUM_TAPS_RST;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         issue_vld_ff <= issue_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_USED_LEN: used_len_ff <= csr_wdata;
               CSR_NUM_TAPS: num_taps_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cbfir_ram #(
      .DEPTH (BUF_DEPTH),
      .WIDTH (SAMPLE_BITS),
      .AW    (AW)
   ) u_sample_ram (
      .clock (clock),
      .reset (reset),
      .clear (smp_clr),
      .we    (smp_we),
      .waddr (smp_waddr),
      .wdata (req_data.sample),
      .raddr (idx_ff),
      .rdata (smp_rdata)
   );

   cbfir_ram #(
      .DEPTH (BUF_DEPTH),
      .WIDTH (TAP_BITS),
      .AW    (AW)
   ) u_tap_ram (
      .clock (clock),
      .reset (reset),
      .clear (1'b0),
      .we    (tap_we),
      .waddr (AW'(req_data.tap_index)),
      .wdata (req_data.tap_value),
      .raddr (term_ff[AW-1:0]),
      .rdata (tap_rdata)
   );

   cbfir_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .clear        (acc_clr),
      .term_valid   (issue_vld_ff),
      .sample       ($signed(smp_rdata)),
      .tap          ($signed(tap_rdata)),
      .acc          (acc),
      .prod_pending (prod_pending)
   );

   // term counter and sample index stay inside the current run
   a_issue_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (term_ff < nterm_ff) && (CW'(idx_ff) < len_eff))
      else $error("issue counter or sample index out of range");

   // a push result is always tagged as position zero and last of run
   a_push_tag: assert property (@(posedge clock) disable iff (reset)
      (emit && !mode_blk_ff) |=>
         rsp_valid && rsp_data.last_of_run && (rsp_data.out_position == '0))
      else $error("push result carries wrong position or last flag");

   // a clear request resets the write position
   a_clear_wp: assert property (@(posedge clock) disable iff (reset)
      smp_clr |=> (wp_ff == '0))
      else $error("write position not zero after clear");

endmodule

`default_nettype wire

/* test/circular_buffer_fir_filter_tb.sv */
// circular_buffer_fir_filter_tb: self-checking bench for the circular buffer fir filter
// a mirror of the sample, tap and register state predicts every response, checked in order
// depends on cbfir_pkg and circular_buffer_fir_filter
`timescale 1ns / 1ps

module circular_buffer_fir_filter_tb
   import cbfir_pkg::*;
;

   localparam int BUF_DEPTH = DEPTH_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_USED_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_TAPS    = 1'b1;
   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_OFF_CYCLES = 400;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   cbfir_req_type        req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   cbfir_rsp_type        rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // mirror of the block state
   logic [CFG_W-1:0]              cfg_used_length = USED_LEN_RST;
   logic [CFG_W-1:0]              cfg_num_taps    = NUM_TAPS_RST;
   logic signed [SAMPLE_BITS-1:0] sample_mirror [BUF_DEPTH];
   logic signed [TAP_BITS-1:0]    tap_mirror [BUF_DEPTH];
   logic [POS_W-1:0]              head_mirror = '0;

   cbfir_rsp_type fir_expected [$];
   int unsigned   error_count = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_idle_pct = 0;
   bit            hold_off_req = 1'b0;

   circular_buffer_fir_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (sample_mirror[k]) sample_mirror[k] = '0;
      foreach (tap_mirror[k]) tap_mirror[k] = '0;
   end

   function automatic int active_length();
      if (cfg_used_length < MIN_LEN) return MIN_LEN;
      if (cfg_used_length > BUF_DEPTH) return BUF_DEPTH;
      return int'(cfg_used_length);
   endfunction

   // updates the mirror and queues the responses that one request causes
   function automatic void predict_fir_results(input cbfir_req_type r);
      int            len;
      int            taps;
      int            head;
      int            at;
      longint        acc;
      cbfir_rsp_type rsp;
      len  = active_length();
      taps = (cfg_num_taps < len) ? int'(cfg_num_taps) : len;
      head = (head_mirror < len) ? int'(head_mirror) : 0;
      case (r.req_type)
         REQ_PUSH: begin
            sample_mirror[head] = r.sample;
            head = (head + 1 == len) ? 0 : head + 1;
            head_mirror = POS_W'(head);
            acc = 0;
            at = head;
            for (int k = 0; k < taps; k++) begin
               at = (at != 0) ? at - 1 : len - 1;
               acc += longint'(sample_mirror[at]) * longint'(tap_mirror[k]);
            end
            rsp.fir_out      = OUT_W'(acc);
            rsp.out_position = '0;
            rsp.last_of_run  = 1'b1;
            fir_expected.push_back(rsp);
         end
         REQ_BLOCK: begin
            // zero-start convolution from the oldest position
            for (int pos = 0; pos < len; pos++) begin
               acc = 0;
               for (int k = 0; k < taps && k <= pos; k++) begin
                  acc += longint'(sample_mirror[(head + pos - k) % len])
                         * longint'(tap_mirror[k]);
               end
               rsp.fir_out      = OUT_W'(acc);
               rsp.out_position = POS_W'(pos);
               rsp.last_of_run  = (pos + 1 == len);
               fir_expected.push_back(rsp);
            end
         end
         REQ_TAP: tap_mirror[r.tap_index] = r.tap_value;
         REQ_CLEAR: begin
            foreach (sample_mirror[k]) sample_mirror[k] = '0;
            head_mirror = '0;
         end
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      cbfir_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (fir_expected.size() == 0) begin
            $error("response with none outstanding: fir_out %0d", rsp_data.fir_out);
            error_count++;
         end else begin
            want = fir_expected.pop_front();
            if (rsp_data.fir_out !== want.fir_out) begin
               $error("fir_out expected %0d actual %0d", want.fir_out, rsp_data.fir_out);
               error_count++;
            end
            if (rsp_data.out_position !== want.out_position) begin
               $error("out_position expected %0d actual %0d",
                      want.out_position, rsp_data.out_position);
               error_count++;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $error("last_of_run expected %0b actual %0b",
                      want.last_of_run, rsp_data.last_of_run);
               error_count++;
            end
         end
      end
   end

   // response side ready, with a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(input cbfir_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predict_fir_results(r);
   endtask

   task automatic send_op(input req_code_type code, input logic signed [15:0] sample,
                          input logic [TAP_IDX_W-1:0] index, input logic signed [15:0] value);
      cbfir_req_type r;
      r.req_type  = code;
      r.sample    = sample;
      r.tap_index = index;
      r.tap_value = value;
      send_request(r);
   endtask

   // lets every outstanding response arrive, then a settling wait for silent requests
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (fir_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_filter(input logic [CFG_W-1:0] used, input logic [CFG_W-1:0] taps);
      drain_responses();
      csr_valid <= 1'b1;
      csr_index <= CSR_USED_LENGTH;
      csr_wdata <= used;
      do @(posedge clock); while (!csr_ready);
      cfg_used_length = used;
      csr_index <= CSR_NUM_TAPS;
      csr_wdata <= taps;
      do @(posedge clock); while (!csr_ready);
      cfg_num_taps = taps;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] random_word();
      case ($urandom_range(11))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic cbfir_req_type random_request();
      cbfir_req_type r;
      int unsigned   pick;
      pick        = $urandom_range(99);
      r.sample    = random_word();
      r.tap_value = random_word();
      r.tap_index = ($urandom_range(3) == 0) ? TAP_IDX_W'($urandom_range(63))
                                             : TAP_IDX_W'($urandom_range(15));
      if (pick < 55) r.req_type = REQ_PUSH;
      else if (pick < 65) r.req_type = REQ_BLOCK;
      else if (pick < 96) r.req_type = REQ_TAP;
      else r.req_type = REQ_CLEAR;
      return r;
   endfunction

   // reset configuration: one tap over the full buffer
   task automatic test_tap_and_push();
      send_op(REQ_TAP, 16'sh0, 6'd0, 16'sh8000);
      send_op(REQ_TAP, 16'sh0, 6'd63, 16'sh7fff);
      send_op(REQ_PUSH, 16'sh8000, 6'd0, 16'sh0);
      send_op(REQ_PUSH, 16'sh7fff, 6'd0, 16'sh0);
   endtask

   // lengths below and above range, tap counts clamped and zero, full size run
   task automatic test_length_extremes();
      set_filter(7'd0, 7'd127);
      send_op(REQ_TAP, 16'sh0, 6'd1, 16'sh7fff);
      send_op(REQ_PUSH, 16'sh04d2, 6'd0, 16'sh0);
      send_op(REQ_PUSH, 16'sh8000, 6'd0, 16'sh0);
      send_op(REQ_BLOCK, 16'sh0, 6'd0, 16'sh0);
      set_filter(7'd1, 7'd2);
      send_op(REQ_BLOCK, 16'sh0, 6'd0, 16'sh0);
      set_filter(7'd127, 7'd0);
      send_op(REQ_PUSH, 16'sh1234, 6'd0, 16'sh0);
      send_op(REQ_BLOCK, 16'sh0, 6'd0, 16'sh0);
      set_filter(7'd64, 7'd64);
      send_op(REQ_BLOCK, 16'sh0, 6'd0, 16'sh0);
   endtask

   // shrink the length under the write position, then grow it back
   task automatic test_stale_position();
      set_filter(7'd8, 7'd3);
      for (int k = 0; k < 6; k++) send_op(REQ_PUSH, 16'(1000 * (k + 1)), 6'd0, 16'sh0);
      set_filter(7'd4, 7'd3);
      send_op(REQ_PUSH, 16'sh8000, 6'd0, 16'sh0);
      send_op(REQ_BLOCK, 16'sh0, 6'd0, 16'sh0);
      set_filter(7'd8, 7'd3);
      send_op(REQ_BLOCK, 16'sh0, 6'd0, 16'sh0);
   endtask

   task automatic test_clear_samples();
      send_op(REQ_CLEAR, 16'sh7fff, 6'd63, 16'sh7fff);
      send_op(REQ_BLOCK, 16'sh0, 6'd0, 16'sh0);
   endtask

   // responses held off while pushes keep coming, so the block stalls its input
   task automatic test_backpressure();
      set_filter(7'd6, 7'd6);
      hold_off_req = 1'b1;
      for (int k = 0; k < 20; k++) send_op(REQ_PUSH, random_word(), 6'd0, 16'sh0);
      send_op(REQ_BLOCK, 16'sh0, 6'd0, 16'sh0);
      send_op(REQ_BLOCK, 16'sh0, 6'd0, 16'sh0);
   endtask

   task automatic test_random_traffic(input int n_requests);
      int unsigned used;
      int unsigned taps;
      int unsigned cap;
      int          left;
      left = n_requests;
      while (left > 0) begin
         // mostly short buffers so that block runs stay quick
         used = ($urandom_range(7) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 16);
         cap  = (used < MIN_LEN) ? MIN_LEN : (used > BUF_DEPTH ? BUF_DEPTH : used);
         taps = ($urandom_range(7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, cap);
         set_filter(CFG_W'(used), CFG_W'(taps));
         for (int k = 0; k < 30 && left > 0; k++) begin
            send_request(random_request());
            left--;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 26;
      recv_idle_pct = 66;
      test_tap_and_push();
      test_length_extremes();
      test_stale_position();
      test_clear_samples();
      test_random_traffic(120);

      send_idle_pct = 66;
      recv_idle_pct = 26;
      test_random_traffic(120);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_traffic(100);

      drain_responses();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
